[sv/epoch_ms_to_calendar_defines.svh]
// Assertion macros shared by the calendar converter RTL.
// Each macro expects signals named clk and rst in the using module.
`ifndef EPOCH_MS_TO_CALENDAR_DEFINES_SVH
`define EPOCH_MS_TO_CALENDAR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define EMTC_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("epoch_ms_to_calendar: check failed");

// Next-cycle implication, disabled during reset.
`define EMTC_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("epoch_ms_to_calendar: next-cycle check failed");

`endif

[sv/emtc_pkg.sv]
// Shared types, constants and reciprocal multipliers for the calendar converter.
// No dependencies.
package emtc_pkg;

  localparam int MS_W     = 48;
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int MILLIS_W = 10;

  localparam logic [MS_W-1:0] LAST_VALID_MS = 48'd253402300799999;

  // Pipeline depths
  localparam int SPLIT_STAGES     = 6;
  localparam int DATE_STAGES      = 9;
  localparam int TIME_CALC_STAGES = 4;
  localparam int TIME_PAD         = DATE_STAGES - TIME_CALC_STAGES;
  localparam int SPLIT_BASE       = 1;
  localparam int DATE_BASE        = SPLIT_BASE + SPLIT_STAGES;
  localparam int TOTAL_STAGES     = DATE_BASE + DATE_STAGES;

  // Odd divisor factors (power-of-two parts are shifts)
  localparam int unsigned MS_ODD       = 125;     // 1000 = 8 * 125
  localparam int unsigned DAY_ODD      = 675;     // 86400 = 128 * 675
  localparam int unsigned SEC_PER_HOUR = 3600;
  localparam int unsigned SEC_PER_MIN  = 60;
  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned YEARS_PER_ERA = 400;

  localparam logic [21:0] DAYS_TO_EPOCH = 22'd719468;
  localparam logic [17:0] DAYS_PER_ERA  = 18'd146097;
  localparam logic [17:0] CENTURY_DAYS  = 18'd36524;
  localparam logic [17:0] ERA_LAST_DAY  = 18'd146096;

  // Exact reciprocals: q = (x * ceil(2^S / D)) >> S, with 2^S >= 2^N * D
  localparam int SHIFT_MS_HI = 28;
  localparam logic [21:0] RECIP_MS_HI =
    22'(((64'd1 << SHIFT_MS_HI) + 64'd124) / 64'd125);
  localparam int SHIFT_MS_LO = 38;
  localparam logic [31:0] RECIP_MS_LO =
    32'(((64'd1 << SHIFT_MS_LO) + 64'd124) / 64'd125);
  localparam int SHIFT_DAY = 41;
  localparam logic [31:0] RECIP_DAY =
    32'(((64'd1 << SHIFT_DAY) + 64'd674) / 64'd675);
  localparam int SHIFT_HOUR = 21;
  localparam logic [13:0] RECIP_HOUR =
    14'(((64'd1 << SHIFT_HOUR) + 64'd224) / 64'd225);
  localparam int SHIFT_MIN = 14;
  localparam logic [10:0] RECIP_MIN =
    11'(((64'd1 << SHIFT_MIN) + 64'd14) / 64'd15);
  localparam int SHIFT_ERA = 40;
  localparam logic [22:0] RECIP_ERA =
    23'(((64'd1 << SHIFT_ERA) + 64'd146096) / 64'd146097);
  localparam int SHIFT_1460 = 29;
  localparam logic [18:0] RECIP_1460 =
    19'(((64'd1 << SHIFT_1460) + 64'd1459) / 64'd1460);
  localparam int SHIFT_365 = 27;
  localparam logic [18:0] RECIP_365 =
    19'(((64'd1 << SHIFT_365) + 64'd364) / 64'd365);
  localparam int SHIFT_100 = 16;
  localparam logic [9:0] RECIP_100 =
    10'(((64'd1 << SHIFT_100) + 64'd99) / 64'd100);

  typedef struct packed {
    logic [21:0]         z;       // day count from 0000-03-01
    logic [16:0]         sod;     // second of day
    logic [MILLIS_W-1:0] millis;
    logic                sat;
  } emtc_day_t;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
    logic [MILLIS_W-1:0] millis;
    logic                sat;
  } emtc_tod_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } emtc_date_t;

  // First day-of-year of each month in a March-based year
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

[sv/epoch_ms_to_calendar.sv]
// Epoch milliseconds to Gregorian date and time of day, top level.
// Depends on emtc_pkg, emtc_split, emtc_time, emtc_date and the shared assertion macros.
//
// Usage:
//   Input channel in_valid/in_ready carries one request: epoch_ms, the milliseconds
//   since 1970-01-01 00:00:00.000. Output channel out_valid/out_ready returns one
//   result per request: year, month, day_of_month, hour, minute, second, millis and
//   out_of_range, in request order.
//   A request past 9999-12-31 23:59:59.999 raises out_of_range and the fields
//   saturate to that instant.
//   Pipeline: 16 registers (one input register, six split stages, nine date stages
//   whose last one is the output register; the time-of-day fields ride a delay line
//   alongside).
//   Throughput: one request per cycle while out_ready stays high. Each stage of the
//   split, time and date paths holds at most one multiply by a fixed reciprocal.
//   Stall: each stage moves when the one after it is empty or moving, so while the
//   receiver holds out_ready low the pipeline keeps taking requests until every
//   stage is full; in_ready then drops until a result leaves.
//   Reset (rst, synchronous): clear all stage valid bits; in_ready is high the cycle
//   after reset is released. Nothing else needs clearing.
`include "epoch_ms_to_calendar_defines.svh"

module epoch_ms_to_calendar (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [emtc_pkg::MS_W-1:0]        epoch_ms,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [emtc_pkg::YEAR_W-1:0]      year,
  output logic [emtc_pkg::MONTH_W-1:0]     month,
  output logic [emtc_pkg::DAY_W-1:0]       day_of_month,
  output logic [emtc_pkg::HOUR_W-1:0]      hour,
  output logic [emtc_pkg::MINUTE_W-1:0]    minute,
  output logic [emtc_pkg::SECOND_W-1:0]    second,
  output logic [emtc_pkg::MILLIS_W-1:0]    millis,
  output logic                             out_of_range
);
  import emtc_pkg::*;

  localparam logic [TOTAL_STAGES-1:0] STAGE_ONES = '1;

  logic [TOTAL_STAGES-1:0] vld;   // per-stage occupancy
  logic [TOTAL_STAGES-1:0] en;    // per-stage load enable

  logic                    over;
  logic [MS_W-1:0]         ms_next;
  logic [MS_W-1:0]         ms_q;
  logic                    sat_q;

  emtc_day_t               day_info;
  emtc_tod_t               tod;
  emtc_date_t              date;

  logic                    last_instant;  // fields show 9999-12-31 23:59:59.999
  logic                    fields_ok;     // every field inside its calendar range
  logic                    thirty_day;    // April, June, September or November

  // A stage may load when the receiver takes the result or any stage
  // at or after it is empty.
  always_comb begin
    for (int i = 0; i < TOTAL_STAGES; i++) begin
      en[i] = out_ready || ((vld | ~(STAGE_ONES << i)) != STAGE_ONES);
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[TOTAL_STAGES-1];

  // Clamp out-of-range requests to the last representable instant
  assign over    = (epoch_ms > LAST_VALID_MS);
  assign ms_next = over ? LAST_VALID_MS : epoch_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < TOTAL_STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Input register: payload only, no reset
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ms_q  <= ms_next;
      sat_q <= over;
    end
  end

  emtc_split u_split (
    .clk      (clk),
    .en       (en[SPLIT_BASE +: SPLIT_STAGES]),
    .ms       (ms_q),
    .sat      (sat_q),
    .day_info (day_info)
  );

  emtc_time u_time (
    .clk      (clk),
    .en       (en[DATE_BASE +: DATE_STAGES]),
    .day_info (day_info),
    .tod      (tod)
  );

  emtc_date u_date (
    .clk      (clk),
    .en       (en[DATE_BASE +: DATE_STAGES]),
    .day_info (day_info),
    .date     (date)
  );

  assign year         = date.year;
  assign month        = date.month;
  assign day_of_month = date.day;
  assign hour         = tod.hour;
  assign minute       = tod.minute;
  assign second       = tod.second;
  assign millis       = tod.millis;
  assign out_of_range = tod.sat;

  assign last_instant = year == 14'd9999 && month == 4'd12 && day_of_month == 5'd31
                        && hour == 5'd23 && minute == 6'd59 && second == 6'd59
                        && millis == 10'd999;
  assign fields_ok    = year >= 14'd1970 && year <= 14'd9999 && month >= 4'd1
                        && month <= 4'd12 && day_of_month >= 5'd1 && hour <= 5'd23
                        && minute <= 6'd59 && second <= 6'd59 && millis <= 10'd999;
  assign thirty_day   = month == 4'd4 || month == 4'd6 || month == 4'd9
                        || month == 4'd11;

  // Saturated results carry the last instant of year 9999
  `EMTC_CHECK(a_sat_fields, out_valid && out_of_range, last_instant)
  // Every delivered field lies in its calendar range
  `EMTC_CHECK(a_field_range, out_valid, fields_ok)
  // Thirty-day months never show day 31
  `EMTC_CHECK(a_short_month, out_valid && thirty_day, day_of_month <= 5'd30)
  // February never passes day 29
  `EMTC_CHECK(a_february, out_valid && month == 4'd2, day_of_month <= 5'd29)
  // A taken result with an empty stage behind it leaves the output empty
  `EMTC_CHECK_NEXT(a_drain, out_valid && out_ready && !vld[TOTAL_STAGES-2], !out_valid)

endmodule

[sv/emtc_split.sv]
// Splits a clamped millisecond count into day number, second of day and millis.
// Depends on emtc_pkg.
module emtc_split (
  input  logic                        clk,
  input  logic [emtc_pkg::SPLIT_STAGES-1:0] en,
  input  logic [emtc_pkg::MS_W-1:0]   ms,
  input  logic                        sat,
  output emtc_pkg::emtc_day_t         day_info
);
  import emtc_pkg::*;

  // stage 1: high half of ms/1000
  logic [20:0] p1_a;
  logic [23:0] p1_b;
  logic [2:0]  p1_low;
  logic [13:0] p1_qa;
  logic        p1_sat;
  logic [42:0] prod_a;

  // stage 2: fold high remainder into low half
  logic [30:0] p2_t;
  logic [13:0] p2_qa;
  logic [2:0]  p2_low;
  logic        p2_sat;
  logic [20:0] ra_full;

  // stage 3: low half of ms/1000
  logic [23:0] p3_qt;
  logic [30:0] p3_t;
  logic [13:0] p3_qa;
  logic [2:0]  p3_low;
  logic        p3_sat;
  logic [62:0] prod_t;

  // stage 4: seconds and millis
  logic [37:0] p4_sec;
  logic [MILLIS_W-1:0] p4_millis;
  logic        p4_sat;
  logic [30:0] rt_full;

  // stage 5: days
  logic [21:0] p5_qd;
  logic [30:0] p5_u;
  logic [6:0]  p5_sec_lo;
  logic [MILLIS_W-1:0] p5_millis;
  logic        p5_sat;
  logic [62:0] prod_d;

  // stage 6
  logic [30:0] rd_full;

  assign prod_a  = 43'(ms[47:27]) * 43'(RECIP_MS_HI);
  assign ra_full = p1_a - 21'(p1_qa) * 21'(MS_ODD);
  assign prod_t  = 63'(p2_t) * 63'(RECIP_MS_LO);
  assign rt_full = p3_t - 31'(p3_qt) * 31'(MS_ODD);
  assign prod_d  = 63'(p4_sec[37:7]) * 63'(RECIP_DAY);
  assign rd_full = p5_u - 31'(p5_qd) * 31'(DAY_ODD);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1_a   <= ms[47:27];
      p1_b   <= ms[26:3];
      p1_low <= ms[2:0];
      p1_qa  <= prod_a[SHIFT_MS_HI +: 14];
      p1_sat <= sat;
    end
    if (en[1]) begin
      p2_t   <= {ra_full[6:0], p1_b};
      p2_qa  <= p1_qa;
      p2_low <= p1_low;
      p2_sat <= p1_sat;
    end
    if (en[2]) begin
      p3_qt  <= prod_t[SHIFT_MS_LO +: 24];
      p3_t   <= p2_t;
      p3_qa  <= p2_qa;
      p3_low <= p2_low;
      p3_sat <= p2_sat;
    end
    if (en[3]) begin
      p4_sec    <= {p3_qa, p3_qt};
      p4_millis <= {rt_full[6:0], p3_low};
      p4_sat    <= p3_sat;
    end
    if (en[4]) begin
      p5_qd     <= prod_d[SHIFT_DAY +: 22];
      p5_u      <= p4_sec[37:7];
      p5_sec_lo <= p4_sec[6:0];
      p5_millis <= p4_millis;
      p5_sat    <= p4_sat;
    end
    if (en[5]) begin
      day_info.z      <= p5_qd + DAYS_TO_EPOCH;
      day_info.sod    <= {rd_full[9:0], p5_sec_lo};
      day_info.millis <= p5_millis;
      day_info.sat    <= p5_sat;
    end
  end

endmodule

[sv/emtc_time.sv]
// Time of day: hour, minute and second from the second of day, delayed to match the date path.
// Depends on emtc_pkg.
module emtc_time (
  input  logic                             clk,
  input  logic [emtc_pkg::DATE_STAGES-1:0] en,
  input  emtc_pkg::emtc_day_t              day_info,
  output emtc_pkg::emtc_tod_t              tod
);
  import emtc_pkg::*;

  logic [4:0]  t1_h;
  logic [16:0] t1_sod;
  logic [MILLIS_W-1:0] t1_millis;
  logic        t1_sat;
  logic [26:0] prod_h;

  logic [4:0]  t2_h;
  logic [11:0] t2_rem;
  logic [MILLIS_W-1:0] t2_millis;
  logic        t2_sat;
  logic [16:0] rem_h_full;

  logic [4:0]  t3_h;
  logic [5:0]  t3_mi;
  logic [11:0] t3_rem;
  logic [MILLIS_W-1:0] t3_millis;
  logic        t3_sat;
  logic [20:0] prod_m;

  emtc_tod_t   t4;
  logic [11:0] sec_full;

  emtc_tod_t   pad [TIME_PAD];

  assign prod_h     = 27'(day_info.sod[16:4]) * 27'(RECIP_HOUR);
  assign rem_h_full = t1_sod - 17'(t1_h) * 17'(SEC_PER_HOUR);
  assign prod_m     = 21'(t2_rem[11:2]) * 21'(RECIP_MIN);
  assign sec_full   = t3_rem - 12'(t3_mi) * 12'(SEC_PER_MIN);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t1_h      <= prod_h[SHIFT_HOUR +: 5];
      t1_sod    <= day_info.sod;
      t1_millis <= day_info.millis;
      t1_sat    <= day_info.sat;
    end
    if (en[1]) begin
      t2_h      <= t1_h;
      t2_rem    <= rem_h_full[11:0];
      t2_millis <= t1_millis;
      t2_sat    <= t1_sat;
    end
    if (en[2]) begin
      t3_h      <= t2_h;
      t3_mi     <= prod_m[SHIFT_MIN +: 6];
      t3_rem    <= t2_rem;
      t3_millis <= t2_millis;
      t3_sat    <= t2_sat;
    end
    if (en[3]) begin
      t4.hour   <= t3_h;
      t4.minute <= t3_mi;
      t4.second <= sec_full[5:0];
      t4.millis <= t3_millis;
      t4.sat    <= t3_sat;
    end
    // hold fields until the date path catches up
    if (en[TIME_CALC_STAGES]) begin
      pad[0] <= t4;
    end
    for (int i = 1; i < TIME_PAD; i++) begin
      if (en[TIME_CALC_STAGES + i]) begin
        pad[i] <= pad[i-1];
      end
    end
  end

  assign tod = pad[TIME_PAD-1];

endmodule

[sv/emtc_date.sv]
// Gregorian civil date from a day count based at 0000-03-01, using 400-year eras.
// Depends on emtc_pkg.
module emtc_date (
  input  logic                             clk,
  input  logic [emtc_pkg::DATE_STAGES-1:0] en,
  input  emtc_pkg::emtc_day_t              day_info,
  output emtc_pkg::emtc_date_t             date
);
  import emtc_pkg::*;

  logic [21:0] d1_z;
  logic [4:0]  d1_era;
  logic [44:0] prod_z;

  logic [17:0] d2_doe;
  logic [4:0]  d2_era;
  logic [21:0] doe_full;

  logic [6:0]  d3_n1;
  logic [2:0]  d3_c2;
  logic        d3_c3;
  logic [17:0] d3_doe;
  logic [4:0]  d3_era;
  logic [36:0] prod_1;
  logic [2:0]  cent_cnt;

  logic [17:0] d4_v;
  logic [17:0] d4_doe;
  logic [4:0]  d4_era;

  logic [8:0]  d5_yoe;
  logic [17:0] d5_doe;
  logic [4:0]  d5_era;
  logic [36:0] prod_y;

  logic [1:0]  d6_yc;
  logic [13:0] d6_y0;
  logic [8:0]  d6_yoe;
  logic [17:0] d6_doe;
  logic [18:0] prod_c;

  logic [8:0]  d7_doy;
  logic [13:0] d7_y0;
  logic [17:0] yday_base;
  logic [17:0] doy_full;

  logic [3:0]  d8_mp;
  logic [8:0]  d8_doy;
  logic [13:0] d8_y0;
  logic [3:0]  mp_cnt;

  logic [8:0]  day_full;
  logic        jan_feb;

  assign prod_z   = 45'(day_info.z) * 45'(RECIP_ERA);
  assign doe_full = d1_z - 22'(d1_era) * 22'(DAYS_PER_ERA);
  assign prod_1   = 37'(d2_doe) * 37'(RECIP_1460);
  assign cent_cnt = 3'(d2_doe >= CENTURY_DAYS) + 3'(d2_doe >= 18'(2 * CENTURY_DAYS))
                  + 3'(d2_doe >= 18'(3 * CENTURY_DAYS)) + 3'(d2_doe >= ERA_LAST_DAY);
  assign prod_y   = 37'(d4_v) * 37'(RECIP_365);
  assign prod_c   = 19'(d5_yoe) * 19'(RECIP_100);
  assign yday_base = 18'(d6_yoe) * 18'(DAYS_PER_YEAR) + 18'(d6_yoe[8:2]) - 18'(d6_yc);
  assign doy_full = d6_doe - yday_base;
  assign day_full = d8_doy - month_start(d8_mp) + 9'd1;
  // March-based months 10 and 11 are January and February of the next year
  assign jan_feb  = (d8_mp >= 4'd10);

  always_comb begin
    mp_cnt = '0;
    for (int k = 1; k < 12; k++) begin
      mp_cnt = mp_cnt + 4'(d7_doy >= month_start(4'(k)));
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1_z   <= day_info.z;
      d1_era <= prod_z[SHIFT_ERA +: 5];
    end
    if (en[1]) begin
      d2_doe <= doe_full[17:0];
      d2_era <= d1_era;
    end
    if (en[2]) begin
      d3_n1  <= prod_1[SHIFT_1460 +: 7];
      d3_c2  <= cent_cnt;
      d3_c3  <= (d2_doe == ERA_LAST_DAY);
      d3_doe <= d2_doe;
      d3_era <= d2_era;
    end
    if (en[3]) begin
      d4_v   <= d3_doe - 18'(d3_n1) + 18'(d3_c2) - 18'(d3_c3);
      d4_doe <= d3_doe;
      d4_era <= d3_era;
    end
    if (en[4]) begin
      d5_yoe <= prod_y[SHIFT_365 +: 9];
      d5_doe <= d4_doe;
      d5_era <= d4_era;
    end
    if (en[5]) begin
      d6_yc  <= prod_c[SHIFT_100 +: 2];
      d6_y0  <= 14'(d5_yoe) + 14'(d5_era) * 14'(YEARS_PER_ERA);
      d6_yoe <= d5_yoe;
      d6_doe <= d5_doe;
    end
    if (en[6]) begin
      d7_doy <= doy_full[8:0];
      d7_y0  <= d6_y0;
    end
    if (en[7]) begin
      d8_mp  <= mp_cnt;
      d8_doy <= d7_doy;
      d8_y0  <= d7_y0;
    end
    if (en[8]) begin
      date.day   <= day_full[4:0];
      date.month <= jan_feb ? 4'(d8_mp - 4'd9) : 4'(d8_mp + 4'd3);
      date.year  <= d8_y0 + 14'(jan_feb);
    end
  end

endmodule
